// File: rtl/core/bsa_pkg.sv
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

	// Result codes
	typedef enum logic [2:0] {
		ST_ALLOC       = 3'd0,
		ST_TOO_LARGE   = 3'd1,
		ST_FULL        = 3'd2,
		ST_FREED       = 3'd3,
		ST_NULL        = 3'd4,
		ST_NOT_OWNED   = 3'd5,
		ST_DOUBLE_FREE = 3'd6
	} status_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] OBJECT_BYTES_RST = 16'd1;
	localparam logic [6:0]  SLOTS_IN_USE_RST = 7'd64;

	// Size of the slot store; the widths below are fixed to it
	localparam int MAX_SLOTS = 64;

	// Slot numbers and the divider: quotient bits, remainder width
	localparam int unsigned CNT_W = 7;
	localparam int unsigned REM_W = 23;
	localparam logic [2:0]  DIV_TOP_BIT = 3'd6;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic eval;
		logic div;
		logic free_chk;
		logic search;
		logic mul;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_free;
		logic ev_final;
		logic div_last;
		logic hit;
		logic miss_end;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/core/bsa_ifs.sv
// Request and response channel interfaces of the slot allocator.
interface bsa_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] req_bytes;
	logic [31:0] free_addr;

	modport source (output valid, func, req_bytes, free_addr, input ready);
	modport sink (input valid, func, req_bytes, free_addr, output ready);
endinterface

interface bsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  slot_index;
	logic [31:0] slot_addr;
	logic [6:0]  used_slots;
	logic [31:0] bytes_allocated_total;
	logic [31:0] bytes_freed_total;
	logic [31:0] bytes_in_use;
	logic [31:0] alloc_count;
	logic [31:0] free_count;
	logic [31:0] fail_count;

	modport source (output valid, status, slot_index, slot_addr, used_slots,
		bytes_allocated_total, bytes_freed_total, bytes_in_use, alloc_count,
		free_count, fail_count, input ready);
	modport sink (input valid, status, slot_index, slot_addr, used_slots,
		bytes_allocated_total, bytes_freed_total, bytes_in_use, alloc_count,
		free_count, fail_count, output ready);
endinterface

// File: rtl/core/bitmap_slot_allocator_top.sv
// Bitmap slot allocator: next-fit allocate and free over a pool of equal slots.
// Allocate: first check, the 7-step divider for the start slot, then a scan of s slots (1..pool size),
//   one bitmap probe a cycle; free: first check, the 7-step slot-number divider, then the bitmap check.
// Refused at the first check (too large, full, null, outside the pool): goes straight to the result.
// One item at a time; the next is taken once the result is in the output register.
// Reset clears the bitmap, counters and last slot and restores the configuration.
module bitmap_slot_allocator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_wdata,
	bsa_req_if.sink                       req,
	bsa_rsp_if.source                     rsp
);

	bsa_pkg::cmd_t cmd;
	bsa_pkg::sts_t sts;

	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bsa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_func         (req.func),
		.in_req_bytes    (req.req_bytes),
		.in_free_addr    (req.free_addr),
		.cmd             (cmd),
		.sts             (sts),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_status      (rsp.status),
		.out_slot_index  (rsp.slot_index),
		.out_slot_addr   (rsp.slot_addr),
		.out_used_slots  (rsp.used_slots),
		.out_bytes_alloc (rsp.bytes_allocated_total),
		.out_bytes_freed (rsp.bytes_freed_total),
		.out_bytes_live  (rsp.bytes_in_use),
		.out_alloc_cnt   (rsp.alloc_count),
		.out_free_cnt    (rsp.free_count),
		.out_fail_cnt    (rsp.fail_count)
	);

	// not ready again in the cycle after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken again straight after acceptance");

	// only a successful allocation carries an address
	a_addr_only_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status != 3'(bsa_pkg::ST_ALLOC)) |-> rsp.slot_addr == 32'd0)
		else $error("slot address on a result that is no allocation");

	// occupancy never exceeds the slot store
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> 32'(rsp.used_slots) <= 32'(bsa_pkg::MAX_SLOTS))
		else $error("used slot count above pool capacity");

endmodule

// File: rtl/core/bsa_ctrl.sv
// Sequencing state machine of the slot allocator.
module bsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bsa_pkg::sts_t  sts,
	output bsa_pkg::cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EVAL   = 7'b0000010,
		S_DIV    = 7'b0000100,
		S_FREE   = 7'b0001000,
		S_SEARCH = 7'b0010000,
		S_MUL    = 7'b0100000,
		S_RESP   = 7'b1000000
	} state_t;

	state_t state_q, state_nx;

	assign req_ready = (state_q == S_IDLE);

	// Commands follow the state
	always_comb begin
		cmd          = '0;
		cmd.load     = req_ready && req_valid;
		cmd.eval     = (state_q == S_EVAL);
		cmd.div      = (state_q == S_DIV);
		cmd.free_chk = (state_q == S_FREE);
		cmd.search   = (state_q == S_SEARCH);
		cmd.mul      = (state_q == S_MUL);
		cmd.emit     = (state_q == S_RESP) && sts.out_free;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_nx = S_EVAL;
			end
			S_EVAL: begin
				state_nx = sts.ev_final ? S_RESP : S_DIV;
			end
			S_DIV: begin
				if (sts.div_last) state_nx = sts.is_free ? S_FREE : S_SEARCH;
			end
			S_FREE: begin
				state_nx = S_RESP;
			end
			S_SEARCH: begin
				if (sts.hit) state_nx = S_MUL;
				else if (sts.miss_end) state_nx = S_RESP;
			end
			S_MUL: begin
				state_nx = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

endmodule

// File: rtl/core/bsa_dp.sv
// Datapath: configuration, bitmap, divider, slot scan, counters, result register.
module bsa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_wdata,
	input  logic                            in_func,
	input  logic [31:0]                     in_req_bytes,
	input  logic [31:0]                     in_free_addr,
	input  bsa_pkg::cmd_t                   cmd,
	output bsa_pkg::sts_t                   sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [2:0]                      out_status,
	output logic [5:0]                      out_slot_index,
	output logic [31:0]                     out_slot_addr,
	output logic [6:0]                      out_used_slots,
	output logic [31:0]                     out_bytes_alloc,
	output logic [31:0]                     out_bytes_freed,
	output logic [31:0]                     out_bytes_live,
	output logic [31:0]                     out_alloc_cnt,
	output logic [31:0]                     out_free_cnt,
	output logic [31:0]                     out_fail_cnt
);

	localparam int MAX_SLOTS = bsa_pkg::MAX_SLOTS;
	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = bsa_pkg::CNT_W;
	localparam int RW = bsa_pkg::REM_W;

	// configuration
	logic [15:0] obj_q;
	logic [6:0]  slots_q;
	logic [31:0] base_q;

	// allocator state
	logic [MAX_SLOTS-1:0] map_q;
	logic [CW-1:0]        used_q;
	logic [CW-1:0]        last_q;
	logic [31:0]          alloc_sum_q, freed_sum_q, live_q;
	logic [31:0]          alloc_ev_q, free_ev_q, fail_ev_q;

	// item and working registers
	logic                 func_q;
	logic [31:0]          req_q, fa_q;
	logic [RW-1:0]        lim_q;
	logic [RW-1:0]        rem_q;
	logic [15:0]          dsr_q;
	logic [CW-1:0]        quo_q;
	logic [2:0]           bit_q;
	logic [CW-1:0]        scan_q, cnt_q;
	bsa_pkg::status_t     res_status_q;
	logic [CW-1:0]        res_idx_q;
	logic [RW-1:0]        prod_s1;
	logic                 out_valid_q;

	logic [15:0]   size_eff;
	logic [CW-1:0] cap_eff;
	logic [31:0]   off;
	logic          too_large, full, null_addr, not_own, ev_final;
	logic [RW-1:0] trial, rem_nx;
	logic          ge;
	logic [CW-1:0] quo_nx, scan_nx;
	logic          scan_free, miss_end, k_ok;

	// effective slot size and pool size
	assign size_eff = (obj_q == 16'd0) ? 16'd1 : obj_q;
	always_comb begin
		if (slots_q == 7'd0) cap_eff = 7'd1;
		else if (32'(slots_q) > 32'(MAX_SLOTS)) cap_eff = CW'(MAX_SLOTS);
		else cap_eff = slots_q;
	end

	// request checks
	assign off       = fa_q - base_q;
	assign too_large = req_q > 32'(size_eff);
	assign full      = used_q >= cap_eff;
	assign null_addr = (fa_q == 32'd0);
	assign not_own   = (fa_q < base_q) || (off >= 32'(lim_q));
	assign ev_final  = func_q ? (null_addr || not_own) : (too_large || full);

	// restoring divider, one quotient bit a cycle
	assign trial  = RW'(dsr_q) << bit_q;
	assign ge     = rem_q >= trial;
	assign rem_nx = ge ? (rem_q - trial) : rem_q;
	assign quo_nx = quo_q | (ge ? (CW'(1) << bit_q) : '0);

	// slot scan and free check
	assign scan_free = !map_q[IW'(scan_q)];
	assign scan_nx   = (scan_q + CW'(1) == cap_eff) ? '0 : scan_q + CW'(1);
	assign miss_end  = !scan_free && (cnt_q + CW'(1) == cap_eff);
	assign k_ok      = (quo_q < cap_eff) && map_q[IW'(quo_q)];

	always_comb begin
		sts          = '0;
		sts.is_free  = func_q;
		sts.ev_final = ev_final;
		sts.div_last = (bit_q == 3'd0);
		sts.hit      = scan_free;
		sts.miss_end = miss_end;
		sts.out_free = !out_valid_q || out_ready;
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		lim_q <= RW'(size_eff) * RW'(cap_eff);
		if (cmd.load) begin
			func_q <= in_func;
			req_q  <= in_req_bytes;
			fa_q   <= in_free_addr;
		end
		if (cmd.eval) begin
			res_idx_q <= '0;
			if (func_q) res_status_q <= null_addr ? bsa_pkg::ST_NULL : bsa_pkg::ST_NOT_OWNED;
			else res_status_q <= too_large ? bsa_pkg::ST_TOO_LARGE : bsa_pkg::ST_FULL;
			rem_q <= func_q ? off[RW-1:0] : RW'(last_q) + RW'(1);
			dsr_q <= func_q ? size_eff : 16'(cap_eff);
			quo_q <= '0;
			bit_q <= bsa_pkg::DIV_TOP_BIT;
		end
		if (cmd.div) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			bit_q <= bit_q - 3'd1;
			scan_q <= rem_nx[CW-1:0];
			cnt_q  <= '0;
		end
		if (cmd.search) begin
			if (scan_free) begin
				res_status_q <= bsa_pkg::ST_ALLOC;
				res_idx_q    <= scan_q;
			end else if (miss_end) begin
				res_status_q <= bsa_pkg::ST_FULL;
			end
			scan_q <= scan_nx;
			cnt_q  <= cnt_q + CW'(1);
		end
		if (cmd.free_chk) begin
			res_status_q <= k_ok ? bsa_pkg::ST_FREED : bsa_pkg::ST_DOUBLE_FREE;
			res_idx_q    <= k_ok ? quo_q : '0;
		end
		if (cmd.mul) prod_s1 <= RW'(res_idx_q) * RW'(size_eff);
		if (cmd.emit) begin
			out_status      <= res_status_q;
			out_slot_index  <= res_idx_q[5:0];
			out_slot_addr   <= (res_status_q == bsa_pkg::ST_ALLOC) ?
				base_q + 32'(prod_s1) : 32'd0;
			out_used_slots  <= used_q;
			out_bytes_alloc <= alloc_sum_q;
			out_bytes_freed <= freed_sum_q;
			out_bytes_live  <= live_q;
			out_alloc_cnt   <= alloc_ev_q;
			out_free_cnt    <= free_ev_q;
			out_fail_cnt    <= fail_ev_q;
		end
	end

	// configuration, bitmap and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q       <= bsa_pkg::OBJECT_BYTES_RST;
			slots_q     <= bsa_pkg::SLOTS_IN_USE_RST;
			base_q      <= '0;
			map_q       <= '0;
			used_q      <= '0;
			last_q      <= '0;
			alloc_sum_q <= '0;
			freed_sum_q <= '0;
			live_q      <= '0;
			alloc_ev_q  <= '0;
			free_ev_q   <= '0;
			fail_ev_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bsa_pkg::CFG_OBJECT_BYTES: obj_q <= cfg_wdata[15:0];
					bsa_pkg::CFG_SLOTS_IN_USE: slots_q <= cfg_wdata[6:0];
					bsa_pkg::CFG_POOL_BASE:    base_q <= cfg_wdata;
					default: ;
				endcase
			end
			// failed allocations
			if ((cmd.eval && ev_final && !func_q) || (cmd.search && miss_end))
				fail_ev_q <= fail_ev_q + 32'd1;
			// slot found
			if (cmd.search && scan_free) begin
				map_q[IW'(scan_q)] <= 1'b1;
				used_q      <= used_q + CW'(1);
				last_q      <= scan_q;
				alloc_sum_q <= alloc_sum_q + 32'(size_eff);
				live_q      <= live_q + 32'(size_eff);
				alloc_ev_q  <= alloc_ev_q + 32'd1;
			end
			// slot released
			if (cmd.free_chk && k_ok) begin
				map_q[IW'(quo_q)] <= 1'b0;
				if (used_q != '0) used_q <= used_q - CW'(1);
				freed_sum_q <= freed_sum_q + 32'(size_eff);
				live_q      <= live_q - 32'(size_eff);
				free_ev_q   <= free_ev_q + 32'd1;
			end
			// result register
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
